// ===== rtl/keypad_edge_event_queue_unit_macros.svh =====
// Assertion helpers for the keypad event queue.
`ifndef KEYPAD_EDGE_EVENT_QUEUE_UNIT_MACROS_SVH
`define KEYPAD_EDGE_EVENT_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KEQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("keypad event queue: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define KEQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("keypad event queue: next-cycle check failed");

`endif

// ===== rtl/keq_pkg.sv =====
package keq_pkg;

   localparam int KEY_COUNT           = 6;
   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int DATA_W              = 8;
   localparam int CSR_ADDR_W          = 4;
   localparam int CSR_DATA_W          = 32;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_ENABLE     = 2'd0;
   localparam logic [1:0] REG_ACTIVE_LOW = 2'd1;
   localparam logic [1:0] REG_PRESENT    = 2'd2;

   // key action codes
   localparam logic [1:0] ACT_PREV  = 2'd0;
   localparam logic [1:0] ACT_NEXT  = 2'd1;
   localparam logic [1:0] ACT_ENTER = 2'd2;
   localparam logic [1:0] ACT_ESC   = 2'd3;

   typedef struct packed {
      logic                 enable;
      logic                 low_true;
      logic [KEY_COUNT-1:0] present;
   } cfg_type;

   typedef struct packed {
      logic [1:0] action;
      logic       pressed;
   } event_type;

   typedef struct packed {
      logic       capture;
      logic       scan;
      logic [2:0] scan_idx;
      logic       pop;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic enable;
      logic baseline_valid;
      logic out_free;
   } status_type;

   function automatic logic [1:0] action_of_key(input logic [2:0] key);
      logic [1:0] act;
      case (key)
         3'd0:    act = ACT_PREV;
         3'd1:    act = ACT_NEXT;
         3'd2:    act = ACT_PREV;
         3'd3:    act = ACT_NEXT;
         3'd4:    act = ACT_ENTER;
         3'd5:    act = ACT_ESC;
         default: act = ACT_PREV;
      endcase
      return act;
   endfunction

endpackage

// ===== rtl/keq_csr.sv =====
module keq_csr
   import keq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable   <= 1'b0;
         cfg_ff.low_true <= 1'b1;
         cfg_ff.present  <= '1;
      end else if (wr_en) begin
         case (reg_idx)
            REG_ENABLE:     cfg_ff.enable   <= csr_pwdata[0];
            REG_ACTIVE_LOW: cfg_ff.low_true <= csr_pwdata[0];
            REG_PRESENT:    cfg_ff.present  <= csr_pwdata[KEY_COUNT-1:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_ENABLE:     csr_prdata = CSR_DATA_W'(cfg_ff.enable);
         REG_ACTIVE_LOW: csr_prdata = CSR_DATA_W'(cfg_ff.low_true);
         REG_PRESENT:    csr_prdata = CSR_DATA_W'(cfg_ff.present);
         default:        csr_prdata = '0;
      endcase
   end

endmodule

// ===== rtl/keq_ctrl.sv =====
module keq_ctrl
   import keq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_POP,
      ST_RESULT
   } state_type;

   state_type  state_ff;
   logic [2:0] idx_ff;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      cmd          = '0;
      cmd.capture  = accept;
      cmd.scan     = (state_ff == ST_SCAN);
      cmd.scan_idx = idx_ff;
      cmd.pop      = (state_ff == ST_POP);
      cmd.emit     = (state_ff == ST_RESULT) & status.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               idx_ff <= '0;
               if (accept) begin
                  if (!status.enable)              state_ff <= ST_RESULT;
                  else if (!status.baseline_valid) state_ff <= ST_POP;
                  else                             state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (idx_ff == 3'(KEY_COUNT - 1)) begin
                  state_ff <= ST_POP;
               end else begin
                  idx_ff <= idx_ff + 3'd1;
               end
            end
            ST_POP: state_ff <= ST_RESULT;
            ST_RESULT: begin
               if (status.out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/keq_datapath.sv =====
module keq_datapath
   import keq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  cfg_type              cfg,
   input  logic [KEY_COUNT-1:0] key_levels,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output event_type            rsp_event,
   output logic                 rsp_event_valid
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   event_type            event_mem_ff [QUEUE_DEPTH];
   logic [KEY_COUNT-1:0] mask_in, mask_ff, baseline_ff, changed;
   logic                 baseline_valid_ff;
   logic [PTR_W-1:0]     wp_ff, rp_ff, wp_in, rp_in;
   logic                 full, empty, push;
   event_type            push_event, rd_data_ff, rsp_event_ff;
   logic                 rd_valid_ff, rsp_valid_ff, rsp_event_valid_ff;

   assign mask_in = (cfg.low_true ? ~key_levels : key_levels) & cfg.present;
   assign changed = mask_ff ^ baseline_ff;

   assign wp_in = (wp_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign rp_in = (rp_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
   assign full  = (wp_in == rp_ff);
   assign empty = (wp_ff == rp_ff);
   // drop the push on a full ring; later keys still get their try
   assign push  = cmd.scan & changed[cmd.scan_idx] & ~full;

   assign push_event.action  = action_of_key(cmd.scan_idx);
   assign push_event.pressed = mask_ff[cmd.scan_idx];

   always_ff @(posedge clock) begin
      if (push) event_mem_ff[wp_ff] <= push_event;
      if (cmd.pop) rd_data_ff <= event_mem_ff[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_valid_ff <= 1'b0;
         baseline_ff       <= '0;
         wp_ff             <= '0;
         rp_ff             <= '0;
         rd_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (cmd.capture) rd_valid_ff <= 1'b0;
         if (push) wp_ff <= wp_in;
         if (cmd.pop) begin
            baseline_ff       <= mask_ff;
            baseline_valid_ff <= 1'b1;
            if (!empty) begin
               rd_valid_ff <= 1'b1;
               rp_ff       <= rp_in;
            end
         end
         if (cmd.emit)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) mask_ff <= mask_in;
      if (cmd.emit) begin
         rsp_event_ff       <= rd_valid_ff ? rd_data_ff : '0;
         rsp_event_valid_ff <= rd_valid_ff;
      end
   end

   assign status.enable         = cfg.enable;
   assign status.baseline_valid = baseline_valid_ff;
   assign status.out_free       = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event       = rsp_event_ff;
   assign rsp_event_valid = rsp_event_valid_ff;

endmodule

// ===== rtl/keypad_edge_event_queue_unit.sv =====
// An enabled poll with a baseline runs from accept to rsp_tvalid through 6 key scan steps,
// one queue read and one result load; a baseline poll skips the scan, a disabled poll also the read.
// One poll at a time: the next is accepted in the cycle after the result is loaded, and the
// result load waits while the previous result beat is stalled at the output.
// Reset (synchronous, active high): queue empty, no baseline, keypad disabled,
// active-low levels, all six keys present. Queue storage is not cleared.
module keypad_edge_event_queue_unit
   import keq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // poll input
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_W-1:0]     req_tdata,   // [5:0] key_levels, [7:6] zero
   // event output
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_W-1:0]     rsp_tdata,   // [1:0] key_action, [2] key_pressed, [7:3] zero
   output logic [0:0]            rsp_tuser,   // [0] event_valid
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   event_type  rsp_event;
   logic       rsp_event_valid;

   // registers: enable, polarity, present-key mask
   keq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer: accept a poll, step through the keys, pop, load the result
   keq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // mask, baseline, event ring and result register
   keq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .cfg             (cfg),
      .key_levels      (req_tdata[KEY_COUNT-1:0]),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_event       (rsp_event),
      .rsp_event_valid (rsp_event_valid)
   );

   // pack the result beat: action lowest, then the pressed flag
   assign rsp_tdata    = {(DATA_W - 3)'(0), rsp_event.pressed, rsp_event.action};
   assign rsp_tuser[0] = rsp_event_valid;

endmodule

// ===== rtl/keq_checker.sv =====
`include "keypad_edge_event_queue_unit_macros.svh"

module keq_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [0:0] rsp_tuser
);

   // a stalled result beat holds its payload
   `KEQ_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // a beat without an event carries an all-zero payload
   `KEQ_ASSERT_NOW(a_empty_zero, rsp_tvalid && !rsp_tuser[0], rsp_tdata == 8'd0)

   // one poll in flight: no accept in the cycle after an accept
   `KEQ_ASSERT_NEXT(a_one_poll, req_tvalid && req_tready, !req_tready)

endmodule

bind keypad_edge_event_queue_unit keq_checker u_keq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== bench/keypad_edge_event_queue_unit_tb.sv =====
`timescale 1ns / 1ps

module keypad_edge_event_queue_unit_tb;
   import keq_pkg::*;

   localparam int RING_DEPTH   = DEFAULT_QUEUE_DEPTH;
   localparam int QUIET_LIMIT  = 5000;  // cycles with no beat on either side
   localparam int SETTLE       = 20;    // well past the poll latency
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int PHASE_POLLS  = 180;

   // One result beat as the block should present it.
   typedef struct {
      logic      valid;
      event_type ev;
   } poll_result_type;

   // Tracks register settings, the baseline and the event ring, and holds the
   // result beats still owed by the block, oldest first.
   class keypad_event_tracker;
      logic                 enable;
      logic                 low_true;
      logic [KEY_COUNT-1:0] present;
      logic [KEY_COUNT-1:0] baseline;
      logic                 baseline_ok;
      event_type            ring[RING_DEPTH];
      int                   rd_ptr;
      int                   wr_ptr;
      poll_result_type      pending_events[$];
      int                   mismatches;

      function new();
         enable      = 1'b0;
         low_true    = 1'b1;
         present     = '1;
         baseline    = '0;
         baseline_ok = 1'b0;
         rd_ptr      = 0;
         wr_ptr      = 0;
         mismatches  = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_ENABLE:     enable   = value[0];
            REG_ACTIVE_LOW: low_true = value[0];
            REG_PRESENT:    present  = value[KEY_COUNT-1:0];
            default: ;
         endcase
      endfunction

      function logic [1:0] key_action(int k);
         case (k)
            0, 2:    return ACT_PREV;
            1, 3:    return ACT_NEXT;
            4:       return ACT_ENTER;
            default: return ACT_ESC;
         endcase
      endfunction

      // Drop the event when the ring already holds RING_DEPTH-1 entries.
      function void push_event(event_type e);
         if ((wr_ptr + 1) % RING_DEPTH == rd_ptr)
            return;
         ring[wr_ptr] = e;
         wr_ptr = (wr_ptr + 1) % RING_DEPTH;
      endfunction

      function void note_poll(logic [KEY_COUNT-1:0] levels);
         poll_result_type      r;
         logic [KEY_COUNT-1:0] pressed;
         logic [KEY_COUNT-1:0] changed;
         event_type            e;
         r.valid = 1'b0;
         r.ev    = '0;
         if (enable) begin
            pressed = (low_true ? ~levels : levels) & present;
            if (!baseline_ok) begin
               baseline_ok = 1'b1;
            end else begin
               changed = pressed ^ baseline;
               for (int k = 0; k < KEY_COUNT; k++) begin
                  if (changed[k]) begin
                     e.action  = key_action(k);
                     e.pressed = pressed[k];
                     push_event(e);
                  end
               end
            end
            baseline = pressed;
            if (rd_ptr != wr_ptr) begin
               r.valid = 1'b1;
               r.ev    = ring[rd_ptr];
               rd_ptr  = (rd_ptr + 1) % RING_DEPTH;
            end
         end
         pending_events.push_back(r);
      endfunction

      function void check_event(logic valid, logic [DATA_W-1:0] data);
         poll_result_type want;
         if (pending_events.size() == 0) begin
            mismatches++;
            $display("%0t: result beat with nothing owed: event_valid=%0b tdata=%h",
                     $time, valid, data);
            return;
         end
         want = pending_events.pop_front();
         if (valid !== want.valid) begin
            mismatches++;
            $display("%0t: event_valid expected %0b got %0b", $time, want.valid, valid);
         end
         if (data[1:0] !== want.ev.action) begin
            mismatches++;
            $display("%0t: key_action expected %0d got %0d", $time, want.ev.action,
                     data[1:0]);
         end
         if (data[2] !== want.ev.pressed) begin
            mismatches++;
            $display("%0t: key_pressed expected %0b got %0b", $time, want.ev.pressed,
                     data[2]);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata;    // [5:0] key_levels, [7:6] zero
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [DATA_W-1:0]     rsp_tdata;    // [1:0] key_action, [2] key_pressed, [7:3] zero
   logic [0:0]            rsp_tuser;    // [0] event_valid
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   keypad_event_tracker tracker;

   // Idle odds in percent, set per phase by the stimulus thread.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   // The stimulus thread bumps hold_requests; the receiver serves each one once.
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;

   keypad_edge_event_queue_unit #(
      .QUEUE_DEPTH(RING_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 2 ns period: low first, then high.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver: serve a pending long hold-off first, else stall at the phase's odds.
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Sample beats at the rising edge. Check the result before noting a poll
   // taken on the same edge: that result always belongs to an earlier poll.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            tracker.check_event(rsp_tuser[0], rsp_tdata);
         if (req_tvalid && req_tready)
            tracker.note_poll(req_tdata[KEY_COUNT-1:0]);
      end
      // Watchdog: give up once neither side has moved a beat for too long.
      if (reset || (rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("keypad_edge_event_queue_unit_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one poll, called and returning at a falling edge. Leave tvalid high
   // on return: the next call or a drain settles it at this same edge.
   task automatic send_poll(logic [KEY_COUNT-1:0] levels);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(DATA_W - KEY_COUNT){1'b0}}, levels};
      do
         @(posedge clock);
      while (!req_tready);
      @(negedge clock);
   endtask

   // Drop tvalid, wait until every owed result has come, then let the block settle.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (tracker.pending_events.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the value at the rising
   // edge inside the access cycle, before the closing fall.
   task automatic write_reg(logic [1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tracker.set_reg(idx, value);
   endtask

   // Write all three registers; fill the unused upper bits with noise.
   task automatic set_keypad(logic en, logic act_low, logic [KEY_COUNT-1:0] keys);
      write_reg(REG_ENABLE, (CSR_DATA_W'($urandom) & ~CSR_DATA_W'(1)) | en);
      write_reg(REG_ACTIVE_LOW, (CSR_DATA_W'($urandom) & ~CSR_DATA_W'(1)) | act_low);
      write_reg(REG_PRESENT, (CSR_DATA_W'($urandom) & ~CSR_DATA_W'(6'h3F)) | keys);
   endtask

   // Mostly single key flips, as a user would press, plus repeats and noise.
   function automatic logic [KEY_COUNT-1:0] next_levels(logic [KEY_COUNT-1:0] prev);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return prev ^ (KEY_COUNT'(1) << $urandom_range(0, KEY_COUNT - 1));
      if (pick < 75)
         return prev;
      return KEY_COUNT'($urandom);
   endfunction

   initial begin
      logic [KEY_COUNT-1:0] levels;
      logic                 en;
      logic                 act_low;
      logic [KEY_COUNT-1:0] keys;
      tracker     = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      levels      = '1;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Disabled after reset: both extremes must come back as empty beats.
      send_poll(6'h00);
      send_poll(6'h3F);
      drain_results();
      set_keypad(1'b1, 1'b1, 6'h3F);
      // First enabled poll only takes the baseline (all keys up, active low).
      send_poll(6'h3F);
      // Toggle every key on each poll below; the events from all six keys overrun the ring.
      send_poll(6'h00);
      send_poll(6'h3F);
      send_poll(6'h00);
      send_poll(6'h3F);
      // Hold steady until the ring runs dry and empty beats come out.
      repeat (16) send_poll(6'h3F);

      for (int ph = 0; ph < 8; ph++) begin
         drain_results();
         case (ph)
            0:       begin en = 1'b1; act_low = 1'b1; keys = 6'h3F; end
            1:       begin en = 1'b1; act_low = 1'b0; keys = 6'h3F; end
            2:       begin en = 1'b1; act_low = 1'b1; keys = 6'h00; end
            3:       begin en = 1'b0; act_low = 1'b1; keys = 6'h3F; end
            4:       begin en = 1'b1; act_low = 1'b0; keys = KEY_COUNT'($urandom); end
            5:       begin en = 1'b1; act_low = 1'b1; keys = KEY_COUNT'($urandom); end
            6:       begin en = 1'b1; act_low = 1'b0; keys = 6'h2A; end
            default: begin en = 1'b1; act_low = 1'b1; keys = 6'h15; end
         endcase
         set_keypad(en, act_low, keys);
         // Cycle through no idling, sender idling, receiver stalling, both lightly.
         case (ph % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         // Park the receiver while polls keep coming so the input backs up.
         if (ph == 0)
            hold_requests++;
         for (int n = 0; n < PHASE_POLLS; n++) begin
            // Pause the sender midway until every owed result is out.
            if (ph == 1 && n == PHASE_POLLS / 2)
               drain_results();
            levels = next_levels(levels);
            send_poll(levels);
         end
      end

      drain_results();
      if (tracker.mismatches == 0)
         $display("keypad_edge_event_queue_unit_tb passed");
      else
         $display("keypad_edge_event_queue_unit_tb failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/keq_pkg.sv
rtl/keq_csr.sv
rtl/keq_ctrl.sv
rtl/keq_datapath.sv
rtl/keypad_edge_event_queue_unit.sv
rtl/keq_checker.sv
bench/keypad_edge_event_queue_unit_tb.sv
